FILE: src/twrtc_pkg.sv
// Shared types and constants for the three-wire serial clock-chip master.
package twrtc_pkg;

  // Number of bytes moved by a burst transfer and held in the burst buffer.
  localparam int unsigned BURST_BYTES = 8;
  localparam int unsigned BufIdxW     = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
  localparam int unsigned BytePosW    = $clog2(BURST_BYTES + 2);

  // Command codes carried by a request.
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_BREAD  = 3'd3;
  localparam logic [2:0] CMD_BWRITE = 3'd4;
  localparam logic [2:0] CMD_LOAD   = 3'd5;

  // Fixed command bytes for burst transfers and the read flag.
  localparam logic [7:0] BREAD_CMD_BYTE  = 8'hbf;
  localparam logic [7:0] BWRITE_CMD_BYTE = 8'hbe;
  localparam logic [7:0] READ_FLAG       = 8'h01;

  // Register map (word index) and reset values.
  localparam int unsigned PADDR_W        = 4;
  localparam logic [1:0]  REG_CLK_HIGH   = 2'd0;
  localparam logic [1:0]  REG_CLK_LOW    = 2'd1;
  localparam logic [1:0]  REG_GUARD      = 2'd2;
  localparam logic [7:0]  CLK_HIGH_RESET = 8'd50;
  localparam logic [7:0]  CLK_LOW_RESET  = 8'd1;
  localparam logic [7:0]  GUARD_RESET    = 8'd100;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] address_byte;
    logic [7:0] write_data;
    logic [2:0] buffer_slot;
    logic       pin_in;
  } req_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       pin_out;
    logic       pin_drive;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       rejected;
  } res_t;

endpackage

FILE: src/three_wire_rtc_serial_master.sv
// Top level of the three-wire serial clock-chip master: pin sequencer and channels.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         in_valid_i / in_stall_o   in_req_i  (req_t, one tick)
//   result    out        out_valid_o / out_stall_i out_res_o (res_t, pin levels)
//   config    in         APB write/read            clock_high, clock_low, guard
//
// Every request is one tick of the pin sequencer and yields exactly one result.
// A request is taken in every cycle unless the skid register is full. Its result
// is registered into the output register, or, while the output is stalled, into
// a skid register behind it that absorbs one result; in_stall_o rises only while
// that skid register is full. The sequencer state and the pin levels advance only
// on accepted requests, so stalls on either side only stretch time, never the pin
// waveform. Reset (rst_ni low, asynchronous) returns the sequencer to idle with all
// pins low and not driven, and loads the timing registers with 50, 1 and 100.
module three_wire_rtc_serial_master import twrtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output res_t               out_res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_GUARD_ON, PH_LOW, PH_HIGH, PH_GUARD_OFF
  } phase_e;

  typedef enum logic [1:0] {
    K_WRITE, K_READ, K_BREAD, K_BWRITE
  } kind_e;

  // A timing register of zero behaves as one tick.
  function automatic logic [7:0] at_least_one(logic [7:0] v);
    at_least_one = (v == 8'd0) ? 8'd1 : v;
  endfunction

  // The data pin is an input while data bytes of a read are clocked in.
  function automatic logic receiving(kind_e k, logic [BytePosW-1:0] pos);
    receiving = (pos != '0) && (k == K_READ || k == K_BREAD);
  endfunction

  // Configuration registers. The APB port never waits.
  logic [7:0] clk_high_q, clk_low_q, guard_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_high_q <= CLK_HIGH_RESET;
      clk_low_q  <= CLK_LOW_RESET;
      guard_q    <= GUARD_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_CLK_HIGH: clk_high_q <= pwdata[7:0];
        REG_CLK_LOW:  clk_low_q  <= pwdata[7:0];
        REG_GUARD:    guard_q    <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CLK_HIGH: prdata = {24'd0, clk_high_q};
      REG_CLK_LOW:  prdata = {24'd0, clk_low_q};
      REG_GUARD:    prdata = {24'd0, guard_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Sequencer state.
  phase_e              phase_q, phase_d;
  kind_e               kind_q, kind_d;
  logic [2:0]          bit_q, bit_d;
  logic [BytePosW-1:0] byte_q, byte_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          pend_q, pend_d;
  logic [7:0]          dly_q, dly_d;
  logic                ce_q, ce_d, sclk_q, sclk_d, pout_q, pout_d, pdrv_q, pdrv_d;

  // Burst buffer; its contents are undefined until loaded.
  logic [7:0]          burst_mem_q [BURST_BYTES];
  logic                mem_we;
  logic [BufIdxW-1:0]  mem_wa;
  logic [7:0]          mem_wd;

  // Output register and skid register.
  logic                out_valid_q, skid_valid_q;
  res_t                out_q, skid_q, res_d;
  logic                accept, out_free;

  logic                go_low;
  logic [BytePosW-1:0] total;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    pend_d  = pend_q;
    dly_d   = dly_q;
    ce_d    = ce_q;
    sclk_d  = sclk_q;
    pout_d  = pout_q;
    pdrv_d  = pdrv_q;
    mem_we  = 1'b0;
    mem_wa  = '0;
    mem_wd  = in_req_i.write_data;
    go_low  = 1'b0;
    res_d   = '0;
    total   = (kind_q == K_BREAD || kind_q == K_BWRITE) ?
              BytePosW'(BURST_BYTES) : BytePosW'(1);

    if (phase_q == PH_IDLE) begin
      if (in_req_i.command >= CMD_WRITE && in_req_i.command <= CMD_BWRITE) begin
        kind_d = kind_e'(2'(in_req_i.command - CMD_WRITE));
        case (in_req_i.command)
          CMD_WRITE: shift_d = in_req_i.address_byte;
          CMD_READ:  shift_d = in_req_i.address_byte | READ_FLAG;
          CMD_BREAD: shift_d = BREAD_CMD_BYTE;
          default:   shift_d = BWRITE_CMD_BYTE;
        endcase
        pend_d  = in_req_i.write_data;
        bit_d   = 3'd0;
        byte_d  = '0;
        phase_d = PH_GUARD_ON;
        dly_d   = at_least_one(guard_q);
        ce_d    = 1'b1;
        sclk_d  = 1'b0;
        pdrv_d  = 1'b1;
      end else if (in_req_i.command == CMD_LOAD &&
                   32'(in_req_i.buffer_slot) < BURST_BYTES) begin
        mem_we = 1'b1;
        mem_wa = BufIdxW'(in_req_i.buffer_slot);
      end
    end else begin
      res_d.rejected = (in_req_i.command >= CMD_WRITE && in_req_i.command <= CMD_LOAD);
      if (dly_q > 8'd1) begin
        dly_d = dly_q - 8'd1;
      end else begin
        case (phase_q)
          PH_GUARD_ON: go_low = 1'b1;
          PH_LOW: begin
            if (receiving(kind_q, byte_q) && in_req_i.pin_in) begin
              shift_d[bit_q] = 1'b1;
            end
            phase_d = PH_HIGH;
            sclk_d  = 1'b1;
            dly_d   = at_least_one(clk_high_q);
          end
          PH_HIGH: begin
            sclk_d = 1'b0;
            if (bit_q < 3'd7) begin
              bit_d  = bit_q + 3'd1;
              go_low = 1'b1;
            end else begin
              if (receiving(kind_q, byte_q)) begin
                res_d.read_valid = 1'b1;
                res_d.read_data  = shift_q;
                res_d.read_last  = (byte_q >= total);
                if (kind_q == K_BREAD && byte_q <= BytePosW'(BURST_BYTES)) begin
                  mem_we = 1'b1;
                  mem_wa = BufIdxW'(byte_q - BytePosW'(1));
                  mem_wd = shift_q;
                end
              end
              byte_d = byte_q + BytePosW'(1);
              bit_d  = 3'd0;
              if (byte_d > total) begin
                phase_d = PH_GUARD_OFF;
                dly_d   = at_least_one(guard_q);
              end else begin
                case (kind_q)
                  K_WRITE:  shift_d = pend_q;
                  K_BWRITE: shift_d = burst_mem_q[BufIdxW'(byte_d - BytePosW'(1))];
                  default:  shift_d = 8'd0;
                endcase
                go_low = 1'b1;
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
            ce_d    = 1'b0;
            sclk_d  = 1'b0;
          end
        endcase
      end
    end

    // Start of a low clock phase: present the next bit or release the pin.
    if (go_low) begin
      phase_d = PH_LOW;
      sclk_d  = 1'b0;
      dly_d   = at_least_one(clk_low_q);
      if (receiving(kind_d, byte_d)) begin
        pdrv_d = 1'b0;
      end else begin
        pdrv_d = 1'b1;
        pout_d = shift_d[bit_d];
      end
    end

    res_d.chip_enable  = ce_d;
    res_d.serial_clock = sclk_d;
    res_d.pin_out      = pout_d;
    res_d.pin_drive    = pdrv_d;
    res_d.busy_res     = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      kind_q       <= K_WRITE;
      bit_q        <= 3'd0;
      byte_q       <= '0;
      shift_q      <= 8'd0;
      pend_q       <= 8'd0;
      dly_q        <= 8'd0;
      ce_q         <= 1'b0;
      sclk_q       <= 1'b0;
      pout_q       <= 1'b0;
      pdrv_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        bit_q   <= bit_d;
        byte_q  <= byte_d;
        shift_q <= shift_d;
        pend_q  <= pend_d;
        dly_q   <= dly_d;
        ce_q    <= ce_d;
        sclk_q  <= sclk_d;
        pout_q  <= pout_d;
        pdrv_q  <= pdrv_d;
      end
      if (out_free) begin
        out_valid_q  <= skid_valid_q || accept;
        skid_valid_q <= 1'b0;
      end else if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Result payload: the skid entry drains first, so results keep their order.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      burst_mem_q[mem_wa] <= mem_wd;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

FILE: src/twrtc_checker.sv
// Port-level checks for the three-wire serial clock-chip master, with its bind.
module twrtc_checker import twrtc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input req_t               in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input res_t               out_res_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // A stalled result stays and does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result changed or dropped");

  // Enable is high exactly while a transfer is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.chip_enable == out_res_o.busy_res)
    else $error("chip enable disagrees with busy");

  // A received byte completes with the clock low and the data pin released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.read_valid |->
      out_res_o.chip_enable && !out_res_o.serial_clock && !out_res_o.pin_drive)
    else $error("read completed with wrong pin state");

  // A last-byte mark only ever comes with a received byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.read_last |-> out_res_o.read_valid)
    else $error("last flag without a received byte");

endmodule

bind three_wire_rtc_serial_master twrtc_checker u_twrtc_checker (.*);

FILE: sim/three_wire_rtc_serial_master_tb.sv
// Self-checking testbench for the three-wire serial clock-chip master.
`timescale 1ns / 100ps

module three_wire_rtc_serial_master_tb;
  import twrtc_pkg::*;

  // Spare command codes: the block treats them as plain ticks and never rejects them.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // How the sampled data pin behaves while a transfer runs.
  localparam int PIN_LOW    = 0;
  localparam int PIN_HIGH   = 1;
  localparam int PIN_RANDOM = 2;

  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_TAIL  = 10;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_GUARD_ON, SEQ_CLK_LOW, SEQ_CLK_HIGH, SEQ_GUARD_OFF
  } seq_state_e;

  typedef enum logic [1:0] {
    XF_WRITE, XF_READ, XF_BURST_READ, XF_BURST_WRITE
  } xfer_e;

  // Tracks the pin sequencer tick by tick and holds the pin levels each
  // accepted request must produce, oldest first.
  class rtc_pin_tracker;
    logic [7:0]          high_ticks, low_ticks, guard_ticks;
    seq_state_e          state;
    xfer_e               kind;
    logic [2:0]          bit_pos;
    logic [BytePosW-1:0] byte_pos;
    logic [7:0]          shreg, held_data, countdown;
    logic [7:0]          burst_copy [BURST_BYTES];
    logic [BURST_BYTES-1:0] slot_loaded;
    logic                ce, sclk, dout, drive;
    res_t                pin_levels_due[$];
    int                  failures;

    function new();
      high_ticks  = CLK_HIGH_RESET;
      low_ticks   = CLK_LOW_RESET;
      guard_ticks = GUARD_RESET;
      state       = SEQ_IDLE;
      kind        = XF_WRITE;
      bit_pos     = '0;
      byte_pos    = '0;
      shreg       = '0;
      held_data   = '0;
      countdown   = '0;
      slot_loaded = '0;
      ce          = 1'b0;
      sclk        = 1'b0;
      dout        = 1'b0;
      drive       = 1'b0;
      failures    = 0;
      foreach (burst_copy[i]) burst_copy[i] = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_CLK_HIGH: high_ticks  = value;
        REG_CLK_LOW:  low_ticks   = value;
        REG_GUARD:    guard_ticks = value;
        default: ;
      endcase
    endfunction

    // A zero timing register behaves like one tick.
    function logic [7:0] ticks_of(logic [7:0] value);
      return (value == 8'd0) ? 8'd1 : value;
    endfunction

    function logic shifting_in();
      return byte_pos != '0 && (kind == XF_READ || kind == XF_BURST_READ);
    endfunction

    // The clock drops; a sending bit goes onto the pin, a receiving bit releases it.
    function void start_low_half();
      state     = SEQ_CLK_LOW;
      sclk      = 1'b0;
      countdown = ticks_of(low_ticks);
      if (shifting_in()) begin
        drive = 1'b0;
      end else begin
        drive = 1'b1;
        dout  = shreg[bit_pos];
      end
    endfunction

    function logic busy();
      return state != SEQ_IDLE;
    endfunction

    function logic buffer_full();
      return &slot_loaded;
    endfunction

    function int pending();
      return pin_levels_due.size();
    endfunction

    function void take_request(req_t r);
      res_t due;
      logic launch;
      int   total;
      due    = '0;
      launch = 1'b0;
      if (state == SEQ_IDLE) begin
        case (r.command)
          CMD_WRITE: begin
            kind   = XF_WRITE;
            shreg  = r.address_byte;
            launch = 1'b1;
          end
          CMD_READ: begin
            kind   = XF_READ;
            shreg  = r.address_byte | READ_FLAG;
            launch = 1'b1;
          end
          CMD_BREAD: begin
            kind   = XF_BURST_READ;
            shreg  = BREAD_CMD_BYTE;
            launch = 1'b1;
          end
          CMD_BWRITE: begin
            kind   = XF_BURST_WRITE;
            shreg  = BWRITE_CMD_BYTE;
            launch = 1'b1;
          end
          CMD_LOAD: begin
            if (r.buffer_slot < BURST_BYTES) begin
              burst_copy[r.buffer_slot]  = r.write_data;
              slot_loaded[r.buffer_slot] = 1'b1;
            end
          end
          default: ;
        endcase
        if (launch) begin
          held_data = r.write_data;
          bit_pos   = '0;
          byte_pos  = '0;
          state     = SEQ_GUARD_ON;
          countdown = ticks_of(guard_ticks);
          ce        = 1'b1;
          sclk      = 1'b0;
          drive     = 1'b1;
        end
      end else begin
        if (r.command >= CMD_WRITE && r.command <= CMD_LOAD) due.rejected = 1'b1;
        if (countdown > 8'd1) begin
          countdown--;
        end else begin
          case (state)
            SEQ_GUARD_ON: start_low_half();
            SEQ_CLK_LOW: begin
              // The read bit is taken on the last low tick, before the clock rises.
              if (shifting_in() && r.pin_in) shreg[bit_pos] = 1'b1;
              state     = SEQ_CLK_HIGH;
              sclk      = 1'b1;
              countdown = ticks_of(high_ticks);
            end
            SEQ_CLK_HIGH: begin
              sclk = 1'b0;
              if (bit_pos < 3'd7) begin
                bit_pos++;
                start_low_half();
              end else begin
                total = (kind == XF_BURST_READ || kind == XF_BURST_WRITE) ? BURST_BYTES : 1;
                if (shifting_in()) begin
                  due.read_valid = 1'b1;
                  due.read_data  = shreg;
                  due.read_last  = (byte_pos >= total);
                  if (kind == XF_BURST_READ && byte_pos >= 1 && byte_pos <= BURST_BYTES) begin
                    burst_copy[byte_pos - 1]  = shreg;
                    slot_loaded[byte_pos - 1] = 1'b1;
                  end
                end
                byte_pos++;
                bit_pos = '0;
                if (byte_pos > total) begin
                  state     = SEQ_GUARD_OFF;
                  countdown = ticks_of(guard_ticks);
                end else begin
                  case (kind)
                    XF_WRITE:       shreg = held_data;
                    XF_BURST_WRITE: shreg = burst_copy[(byte_pos - 1) % BURST_BYTES];
                    default:        shreg = '0;
                  endcase
                  start_low_half();
                end
              end
            end
            default: begin
              state = SEQ_IDLE;
              ce    = 1'b0;
              sclk  = 1'b0;
            end
          endcase
        end
      end
      due.chip_enable  = ce;
      due.serial_clock = sclk;
      due.pin_out      = dout;
      due.pin_drive    = drive;
      due.busy_res     = (state != SEQ_IDLE);
      pin_levels_due.push_back(due);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pin_levels_due.size() == 0) begin
        $error("result arrived with no request outstanding: %h", got);
        failures++;
        return;
      end
      want = pin_levels_due.pop_front();
      compare_field("chip_enable",  want.chip_enable,  got.chip_enable);
      compare_field("serial_clock", want.serial_clock, got.serial_clock);
      compare_field("pin_out",      want.pin_out,      got.pin_out);
      compare_field("pin_drive",    want.pin_drive,    got.pin_drive);
      compare_field("busy_res",     want.busy_res,     got.busy_res);
      compare_field("read_valid",   want.read_valid,   got.read_valid);
      compare_field("read_data",    want.read_data,    got.read_data);
      compare_field("read_last",    want.read_last,    got.read_last);
      compare_field("rejected",     want.rejected,     got.rejected);
    endfunction
  endclass

  // Every input starts at a known level from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  req_t               in_req_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  res_t               out_res_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  rtc_pin_tracker pins;
  event           request_taken;
  int unsigned    cycle_count = 0;
  int             items_sent  = 0;
  // steady switches idling off on both sides. Each step of hold_asked asks the
  // receiver for one long stall; hold_done counts the stalls it has started.
  logic           steady      = 1'b0;
  int             hold_asked  = 0;
  int             hold_done   = 0;

  three_wire_rtc_serial_master uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Both handshakes are observed at the rising edge, before any register in the
  // block updates. An accepted request is fed to the tracker first and the
  // sender is told through request_taken, so the sender always sees the tracker
  // state that includes its own request when it picks the next one.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pins.take_request(in_req_i);
        -> request_taken;
      end
      if (out_valid_o && !out_stall_i) pins.check_result(out_res_o);
    end
  end

  // Mostly no gap, sometimes a short one, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Timing values stay at the fast end, at most two, so that transfers stay
  // short; zero appears now and then.
  function automatic logic [7:0] pick_timing();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return 8'd0;
    if (roll < 70) return 8'd1;
    return 8'd2;
  endfunction

  function automatic req_t random_request(logic [2:0] cmd);
    req_t r;
    r.command      = cmd;
    r.address_byte = 8'($urandom);
    r.write_data   = 8'($urandom);
    r.buffer_slot  = 3'($urandom);
    r.pin_in       = 1'($urandom);
    return r;
  endfunction

  // The receiver stalls in runs of random length. When a long stall is asked
  // for it stalls without a break so the skid register fills and the block
  // pushes back on the sender, which keeps offering requests.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (!steady && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                  : $urandom_range(8, 50);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Presents one request after a random gap and returns once it is accepted.
  // Valid stays high from one request to the next when there is no gap.
  task automatic offer(input req_t r);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(request_taken);
    items_sent++;
  endtask

  // Stops sending and waits until every outstanding result has been taken.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pins.pending() != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reads one timing register and compares it with the value it should hold.
  task automatic check_reg(input logic [1:0] idx, input logic [7:0] want);
    logic [31:0] readback;
    apb_access(1'b0, idx, 32'h0, readback);
    if (readback[7:0] !== want) begin
      $error("register %0d: expected %0h, got %0h", idx, want, readback[7:0]);
      pins.failures++;
    end
  endtask

  // Writes one timing register, reads it back and mirrors it in the tracker.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    logic [31:0] readback;
    apb_access(1'b1, idx, {24'h0, value}, readback);
    apb_access(1'b0, idx, 32'h0, readback);
    if (readback[7:0] !== value) begin
      $error("register %0d readback: expected %0h, got %0h", idx, value, readback[7:0]);
      pins.failures++;
    end
    pins.set_register(idx, value);
  endtask

  // Timing changes only happen with the channels empty, so they fall between
  // requests exactly where the tracker applies them.
  task automatic program_timing(input logic [7:0] high, input logic [7:0] low,
                                input logic [7:0] guard);
    drain();
    write_reg(REG_CLK_HIGH, high);
    write_reg(REG_CLK_LOW, low);
    write_reg(REG_GUARD, guard);
  endtask

  // Loads all burst slots with random data, starting at a random slot.
  task automatic fill_buffer();
    req_t r;
    int   first;
    first = $urandom_range(0, BURST_BYTES - 1);
    for (int i = 0; i < BURST_BYTES; i++) begin
      r             = random_request(CMD_LOAD);
      r.buffer_slot = 3'((first + i) % BURST_BYTES);
      offer(r);
    end
  endtask

  // Starts one transfer and ticks it through to the end. While it runs, a
  // share of the ticks carry random codes; the block must reject transfer and load codes.
  task automatic run_transfer(input logic [2:0] cmd, input logic [7:0] addr,
                              input logic [7:0] data, input int pin_mode,
                              input int noise_pct);
    req_t r;
    // A burst write must never send a slot that was never loaded.
    if (cmd == CMD_BWRITE && !pins.buffer_full()) fill_buffer();
    r              = random_request(cmd);
    r.address_byte = addr;
    r.write_data   = data;
    offer(r);
    while (pins.busy()) begin
      r = random_request(CMD_TICK);
      if ($urandom_range(0, 99) < noise_pct) r.command = 3'($urandom_range(0, 7));
      case (pin_mode)
        PIN_LOW:  r.pin_in = 1'b0;
        PIN_HIGH: r.pin_in = 1'b1;
        default: ;
      endcase
      offer(r);
    end
  endtask

  // Single transfers, a few bursts and buffer fills with random content; the
  // rest are lone loads and idle ticks with spare codes. The quota counts
  // requests, and a transfer that is under way is always finished.
  task automatic run_random_phase(input int quota);
    int stop_at;
    int roll;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        run_transfer(3'(CMD_WRITE + $urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                     PIN_RANDOM, 8);
      end else if (roll < 36) begin
        run_transfer(3'(CMD_BREAD + $urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                     PIN_RANDOM, 8);
      end else if (roll < 50) begin
        fill_buffer();
      end else if (roll < 75) begin
        offer(random_request(CMD_LOAD));
      end else begin
        case ($urandom_range(0, 2))
          0:       offer(random_request(CMD_TICK));
          1:       offer(random_request(CMD_SPARE_6));
          default: offer(random_request(CMD_SPARE_7));
        endcase
      end
    end
  endtask

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("three_wire_rtc_serial_master test failed");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    pins = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The timing registers come out of reset with their documented values.
    check_reg(REG_CLK_HIGH, CLK_HIGH_RESET);
    check_reg(REG_CLK_LOW, CLK_LOW_RESET);
    check_reg(REG_GUARD, GUARD_RESET);

    // Spare codes on an idle block are plain ticks and must not be rejected.
    offer(random_request(CMD_TICK));
    offer(random_request(CMD_SPARE_6));
    offer(random_request(CMD_SPARE_7));
    for (int s = 0; s < BURST_BYTES; s++) begin
      r             = random_request(CMD_LOAD);
      r.buffer_slot = 3'(s);
      r.write_data  = (s == 0) ? 8'h00 : (s == BURST_BYTES - 1) ? 8'hff : 8'($urandom);
      offer(r);
    end

    // Zero in every timing register acts as a single tick, which also keeps
    // the directed transfers short.
    program_timing(8'd0, 8'd0, 8'd0);
    run_transfer(CMD_WRITE, 8'h00, 8'hff, PIN_RANDOM, 10);
    // A read forces bit 0 of the command byte even when it is clear.
    run_transfer(CMD_READ, 8'hfe, 8'h00, PIN_HIGH, 0);
    run_transfer(CMD_READ, 8'hff, 8'h55, PIN_LOW, 0);
    run_transfer(CMD_BREAD, 8'($urandom), 8'($urandom), PIN_RANDOM, 0);
    run_transfer(CMD_BWRITE, 8'($urandom), 8'($urandom), PIN_RANDOM, 0);
    // Heavy stray traffic, loads included, while a write is in flight.
    run_transfer(CMD_WRITE, 8'hff, 8'h00, PIN_RANDOM, 30);

    // Random part. The first phase runs back to back with no idling at all.
    program_timing(8'd1, 8'd1, 8'd1);
    steady = 1'b1;
    run_random_phase(50);
    steady = 1'b0;
    for (int ph = 0; ph < 2; ph++) begin
      program_timing(pick_timing(), pick_timing(), pick_timing());
      if (ph == 0) hold_asked++;
      run_random_phase(30);
      // Let the block run dry once in the middle of a phase.
      if (ph == 1) drain();
      run_random_phase(30);
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (pins.failures == 0 && pins.pending() == 0) begin
      $display("three_wire_rtc_serial_master test passed");
    end else begin
      $display("three_wire_rtc_serial_master test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/twrtc_pkg.sv
src/three_wire_rtc_serial_master.sv
src/twrtc_checker.sv
sim/three_wire_rtc_serial_master_tb.sv
